>>> rtl/hfd_pkg.sv
package hfd_pkg;

   localparam int CFG_W      = 4;
   localparam int SHIFT_W    = 5;
   localparam int ROW_W      = 11;
   localparam int IDX_W      = 10;
   localparam int SAMPLE_W   = 32;
   localparam int STATUS_W   = 2;
   localparam int RESET_LOG2 = 10;

   localparam logic OP_STORE  = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_UNUSED = 2'd1,
      STATUS_RANGE  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       clear;
      logic       add;
      logic       negate;
      logic       finish;
      logic       reject;
      status_type status;
   } acc_ctrl_type;

endpackage

>>> rtl/hfd_ram.sv
module hfd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/hfd_seq.sv
module hfd_seq #(
   parameter int MAX_FRAMES = 1024,
   localparam int AW        = $clog2(MAX_FRAMES)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        operation,
   input  logic [hfd_pkg::ROW_W-1:0]   mode_row,
   input  logic [hfd_pkg::CFG_W-1:0]   frames_log2,
   output logic                        busy,
   output logic                        rd_en,
   output logic [AW-1:0]               rd_addr,
   output hfd_pkg::acc_ctrl_type       ctrl,
   output logic [hfd_pkg::SHIFT_W-1:0] shift
);

   import hfd_pkg::*;

   localparam int LIM = $clog2(MAX_FRAMES + 1) - 1;
   localparam int PW  = (AW > IDX_W) ? AW : IDX_W;

   state_type          state_ff, state_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      last_ff, last_in;
   logic [AW-1:0]      ones_sh;
   logic [IDX_W-1:0]   row_ff, row_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [SHIFT_W-1:0] eff_log2;
   logic               add_ff, add_in;
   logic               neg_ff, neg_in;
   logic               accept;
   logic               row_big;

   // register is clamped to 1 .. floor(log2(MAX_FRAMES))
   always_comb begin
      if (frames_log2 == '0) begin
         eff_log2 = SHIFT_W'(1);
      end else if (SHIFT_W'(frames_log2) > SHIFT_W'(LIM)) begin
         eff_log2 = SHIFT_W'(LIM);
      end else begin
         eff_log2 = SHIFT_W'(frames_log2);
      end
   end

   assign row_big = (mode_row[IDX_W-1:0] >> eff_log2) != '0;
   assign ones_sh = {AW{1'b1}} << eff_log2;
   assign accept  = start && (state_ff == ST_IDLE) && (operation == OP_DECODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         add_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         add_ff   <= add_in;
      end
      cnt_ff   <= cnt_in;
      last_ff  <= last_in;
      row_ff   <= row_in;
      shift_ff <= shift_in;
      neg_ff   <= neg_in;
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      last_in     = last_ff;
      row_in      = row_ff;
      shift_in    = shift_ff;
      add_in      = 1'b0;
      neg_in      = 1'b0;
      rd_en       = 1'b0;
      ctrl        = '0;
      ctrl.status = STATUS_OK;
      ctrl.add    = add_ff;
      ctrl.negate = neg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (mode_row[ROW_W-1]) begin
                  ctrl.reject = 1'b1;
                  ctrl.status = STATUS_UNUSED;
               end else if (row_big) begin
                  ctrl.reject = 1'b1;
                  ctrl.status = STATUS_RANGE;
               end else begin
                  ctrl.clear = 1'b1;
                  row_in     = mode_row[IDX_W-1:0];
                  shift_in   = eff_log2;
                  last_in    = ~ones_sh;
                  cnt_in     = '0;
                  state_in   = ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_en  = 1'b1;
            add_in = 1'b1;
            // Sylvester sign: parity of row AND frame
            neg_in = ^(PW'(row_ff) & PW'(cnt_ff));
            if (cnt_ff == last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            ctrl.finish = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy    = state_ff != ST_IDLE;
   assign rd_addr = cnt_ff;
   assign shift   = shift_ff;

endmodule

>>> rtl/hfd_acc.sv
module hfd_acc #(
   parameter int MAX_FRAMES = 1024,
   localparam int AW        = $clog2(MAX_FRAMES),
   localparam int ACC_W     = hfd_pkg::SAMPLE_W + AW + 1
) (
   input  logic                                clock,
   input  hfd_pkg::acc_ctrl_type               ctrl,
   input  logic [hfd_pkg::SHIFT_W-1:0]         shift,
   input  logic [hfd_pkg::SAMPLE_W-1:0]        rd_data,
   output logic signed [hfd_pkg::SAMPLE_W-1:0] result
);

   import hfd_pkg::*;

   localparam logic signed [ACC_W-1:0] POS_MAX =
      {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] NEG_MIN =
      {{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] sample_ext;
   logic signed [ACC_W-1:0] shifted;

   assign sample_ext = {{(ACC_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};

   always_comb begin
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.add) begin
         acc_in = ctrl.negate ? (acc_ff - sample_ext) : (acc_ff + sample_ext);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // arithmetic shift floors; only +2^31 can overflow
   assign shifted = acc_ff >>> shift;

   always_comb begin
      if (shifted > POS_MAX) begin
         result = POS_MAX[SAMPLE_W-1:0];
      end else if (shifted < NEG_MIN) begin
         result = NEG_MIN[SAMPLE_W-1:0];
      end else begin
         result = shifted[SAMPLE_W-1:0];
      end
   end

endmodule

>>> rtl/hadamard_frame_decoder_core.sv
// Hadamard frame decoder for one sensor pixel.
// Command channel: a word is taken at a rising edge with start high and busy low.
// req_operation 0 stores req_sample (Q16.16) for frame req_frame_index; it gives
// no result and busy stays low. req_operation 1 decodes Hadamard row req_mode_row
// over F = 2^frames_log2 frames, with frames_log2 clamped to 1 .. log2(MAX_FRAMES).
// A valid row walks the sample memory, one read and one signed add per cycle, and
// the result shows in the cycle busy falls.
// A negative row or a row at or beyond F gives a zero value with a status code
// in the cycle after acceptance, without raising busy.
// Results: rsp_valid strobes for one cycle with rsp_decoded_value and rsp_status;
// the receiver cannot stall, so nothing is held back.
// csr port: frames_log2 is written whenever csr_valid is high; write it while idle.
// Reset: frames_log2 returns to 10 and the sequencer goes idle; sample memory is
// not cleared and must be stored before it is decoded.
module hadamard_frame_decoder_core #(
   parameter int MAX_FRAMES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_operation,
   input  logic [hfd_pkg::IDX_W-1:0]           req_frame_index,
   input  logic signed [hfd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic signed [hfd_pkg::ROW_W-1:0]    req_mode_row,
   output logic                                rsp_valid,
   output logic signed [hfd_pkg::SAMPLE_W-1:0] rsp_decoded_value,
   output logic [hfd_pkg::STATUS_W-1:0]        rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hfd_pkg::CFG_W-1:0]           csr_wdata
);

   import hfd_pkg::*;

   localparam int AW = $clog2(MAX_FRAMES);

   logic [CFG_W-1:0]           log2_ff;
   logic                       wr_en;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [SAMPLE_W-1:0]        rd_data;
   logic [SHIFT_W-1:0]         shift;
   logic signed [SAMPLE_W-1:0] result;
   acc_ctrl_type               ctrl;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_value_ff, rsp_value_in;
   status_type                 rsp_status_ff, rsp_status_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_ff <= CFG_W'(RESET_LOG2);
      end else if (csr_valid && csr_ready) begin
         log2_ff <= csr_wdata;
      end
   end

   // stores beyond the memory are dropped
   assign wr_en = start && !busy && (req_operation == OP_STORE) &&
                  (32'(req_frame_index) < MAX_FRAMES);

   hfd_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_FRAMES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_frame_index)),
      .wr_data (req_sample),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hfd_seq #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .operation   (req_operation),
      .mode_row    (req_mode_row),
      .frames_log2 (log2_ff),
      .busy        (busy),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .ctrl        (ctrl),
      .shift       (shift)
   );

   hfd_acc #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_acc (
      .clock   (clock),
      .ctrl    (ctrl),
      .shift   (shift),
      .rd_data (rd_data),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in  = ctrl.finish || ctrl.reject;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_in) begin
         rsp_value_in  = ctrl.reject ? '0 : result;
         rsp_status_in = ctrl.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_decoded_value = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

>>> rtl/hfd_checker.sv
module hfd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                req_operation,
   input logic                                rsp_valid,
   input logic signed [hfd_pkg::SAMPLE_W-1:0] rsp_decoded_value,
   input logic [hfd_pkg::STATUS_W-1:0]        rsp_status
);

   import hfd_pkg::*;

   // a failed decode always carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_decoded_value == '0)
   else $error("nonzero value with error status");

   // a store word never produces a result
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_operation == OP_STORE) |=> !rsp_valid)
   else $error("result after store word");

   // a decode that starts the memory walk shows no result yet
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> !rsp_valid)
   else $error("result while decode starting");

   // end of a memory walk always delivers its result
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
   else $error("decode ended without result");

endmodule

bind hadamard_frame_decoder_core hfd_checker u_hfd_checker (.*);
